// ===== hw/rtl/ftcu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftcu_pkg
// Shared widths, codes and helper functions of the four-timer cascade unit.
// ----------------------------------------------------------------------------
package ftcu_pkg;

	localparam int TIMER_SLOTS         = 4;
	localparam int TIMER_COUNT_DEFAULT = 4;

	localparam int CYCLE_W  = 27;
	localparam int PERIOD_W = 17;
	localparam int CTRL_W   = 5;
	localparam int TICKS_W  = 28;
	localparam int WIDE_W   = 30;
	localparam int VALUE_W  = 16;
	localparam int REG_IDX_W = 3;

	localparam logic [PERIOD_W-1:0] FULL_PERIOD = 17'h10000;

	// timer modes, control bits 1:0
	localparam logic [1:0] MODE_OFF      = 2'd0;
	localparam logic [1:0] MODE_PRESCALE = 2'd1;
	localparam logic [1:0] MODE_CASCADE  = 2'd2;

	// register indices
	localparam logic [REG_IDX_W-1:0] REG_PERIOD0  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CONTROL0 = 3'd4;

	localparam int CTRL_IRQ_BIT = 4;

	localparam logic [3:0] SHIFT_TABLE [4] = '{4'd0, 4'd6, 4'd8, 4'd10};

	localparam logic signed [WIDE_W-1:0] SAT_HI = 30'sh07FF_FFFF;
	localparam logic signed [WIDE_W-1:0] SAT_LO = -30'sh0800_0000;

	typedef logic signed [TICKS_W-1:0] ticks_t;

	typedef struct packed {
		logic ovf;
		logic irq;
	} ftcu_flags_t;

	typedef struct packed {
		logic [3:0]          irq_mask;
		logic [3:0]          overflow_mask;
		logic [VALUE_W-1:0]  timer0_value;
		logic [VALUE_W-1:0]  timer1_value;
		logic [VALUE_W-1:0]  timer2_value;
		logic [VALUE_W-1:0]  timer3_value;
		logic [CYCLE_W-1:0]  next_slice;
	} ftcu_result_t;

	function automatic logic [3:0] shift_of(input logic [CTRL_W-1:0] ctrl);
		logic [3:0] s;
		if (ctrl[1:0] == MODE_CASCADE) begin
			s = 4'd0;
		end else begin
			s = SHIFT_TABLE[ctrl[3:2]];
		end
		return s;
	endfunction

	function automatic ticks_t sat28(input logic signed [WIDE_W-1:0] v);
		ticks_t r;
		if (v > SAT_HI) begin
			r = SAT_HI[TICKS_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[TICKS_W-1:0];
		end else begin
			r = v[TICKS_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [WIDE_W-1:0] widen(input ticks_t t);
		return {{(WIDE_W-TICKS_W){t[TICKS_W-1]}}, t};
	endfunction

	// period << shift; at most 27 bits
	function automatic logic [CYCLE_W-1:0] reload_amt(input logic [PERIOD_W-1:0] period,
			input logic [CTRL_W-1:0] ctrl);
		logic [CYCLE_W-1:0] p;
		p = {{(CYCLE_W-PERIOD_W){1'b0}}, period};
		return p << shift_of(ctrl);
	endfunction

	// minus the count, floor-shifted by the prescale, low 16 bits
	function automatic logic [VALUE_W-1:0] visible_of(input ticks_t t,
			input logic [CTRL_W-1:0] ctrl);
		ticks_t q;
		q = t >>> shift_of(ctrl);
		return VALUE_W'(16'd0 - q[VALUE_W-1:0]);
	endfunction

endpackage

// ===== hw/rtl/ftcu_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftcu_sample_if
// Input channel: elapsed cycles and external deadline per word.
// ----------------------------------------------------------------------------
interface ftcu_sample_if import ftcu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CYCLE_W-1:0] elapsed_cycles;
	logic [CYCLE_W-1:0] other_deadline;

	modport source (output valid, elapsed_cycles, other_deadline, input ready);
	modport sink   (input valid, elapsed_cycles, other_deadline, output ready);
endinterface

// ===== hw/rtl/ftcu_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftcu_result_if
// Output channel: masks, visible counters and next time slice per word.
// ----------------------------------------------------------------------------
interface ftcu_result_if import ftcu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [3:0]         irq_mask;
	logic [3:0]         overflow_mask;
	logic [VALUE_W-1:0] timer0_value;
	logic [VALUE_W-1:0] timer1_value;
	logic [VALUE_W-1:0] timer2_value;
	logic [VALUE_W-1:0] timer3_value;
	logic [CYCLE_W-1:0] next_slice;

	modport source (output valid, irq_mask, overflow_mask, timer0_value, timer1_value,
		timer2_value, timer3_value, next_slice, input ready);
	modport sink   (input valid, irq_mask, overflow_mask, timer0_value, timer1_value,
		timer2_value, timer3_value, next_slice, output ready);
endinterface

// ===== hw/rtl/ftcu_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftcu_cfg_if
// Register write channel: index and data per word.
// ----------------------------------------------------------------------------
interface ftcu_cfg_if import ftcu_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [PERIOD_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ftcu_timer_slice.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftcu_timer_slice
// One timer's step: count down or cascade decrement, overflow, reload.
// ----------------------------------------------------------------------------
module ftcu_timer_slice import ftcu_pkg::*; (
	input  logic                active,
	input  logic [CTRL_W-1:0]   ctrl,
	input  logic [PERIOD_W-1:0] period,
	input  logic [CYCLE_W-1:0]  elapsed,
	input  logic                prev_ovf,
	input  ticks_t              ticks_in,
	input  logic [VALUE_W-1:0]  latch_in,
	output ticks_t              ticks_out,
	output logic [VALUE_W-1:0]  latch_out,
	output ftcu_flags_t         flags
);

	logic   run;
	ticks_t t1;

	assign run = active && (ctrl[1:0] inside {MODE_PRESCALE, MODE_CASCADE});

	always_comb begin
		t1        = ticks_in;
		latch_out = latch_in;
		if (run && ctrl[1:0] == MODE_PRESCALE) begin
			t1        = sat28(widen(ticks_in) - $signed({3'b000, elapsed}));
			latch_out = visible_of(t1, ctrl);
		end else if (run && prev_ovf) begin
			// cascade: the previous timer's overflow is this one's tick
			t1        = sat28(widen(ticks_in) - 30'sd1);
			latch_out = visible_of(t1, ctrl);
		end

		flags.ovf = run && (t1 <= 0);
		flags.irq = flags.ovf && ctrl[CTRL_IRQ_BIT];

		// period added once only, even if still overdue
		if (flags.ovf) begin
			ticks_out = sat28(widen(t1) + $signed({3'b000, reload_amt(period, ctrl)}));
		end else begin
			ticks_out = t1;
		end
	end

endmodule

// ===== hw/rtl/four_timer_cascade_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_timer_cascade_unit_core
// Four down-counting timers with prescale and cascade modes.
// ----------------------------------------------------------------------------
// Takes one word per clock unless the output stalls: elapsed processor cycles
// and the next external deadline. Each word gives one result word via the
// input register, then the result register, and words may follow back to
// back; the path between them is the timer chain, 0 to 3, each overflow feeding
// the next timer's cascade decrement, then a four-way minimum for next_slice.
// Timer state is updated on the edge that loads the result register, so the
// next word already sees it. Register writes reload the timer's count with
// period << prescale and refresh its visible value; write them only while no
// word is in flight. The write port is always ready.
// ----------------------------------------------------------------------------
module four_timer_cascade_unit_core import ftcu_pkg::*; #(
	parameter int TIMER_COUNT = TIMER_COUNT_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	ftcu_cfg_if.sink     cfg,
	ftcu_sample_if.sink  sample,
	ftcu_result_if.source result
);

	// register file and timer state
	logic [PERIOD_W-1:0] period_q [TIMER_SLOTS];
	logic [CTRL_W-1:0]   control_q [TIMER_SLOTS];
	ticks_t              ticks_q [TIMER_SLOTS];
	logic [VALUE_W-1:0]  latch_q [TIMER_SLOTS];

	// input register
	logic               valid_s1;
	logic [CYCLE_W-1:0] elapsed_s1;
	logic [CYCLE_W-1:0] deadline_s1;

	// result register
	logic         out_valid_q;
	ftcu_result_t result_q;

	logic advance;
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	// ---- timer chain ----
	ticks_t             ticks_nx [TIMER_SLOTS];
	logic [VALUE_W-1:0] latch_nx [TIMER_SLOTS];
	ftcu_flags_t        flags [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] ovf_chain;

	assign ovf_chain[0] = 1'b0;

	for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_timer
		ftcu_timer_slice u_slice (
			.active    (i < TIMER_COUNT),
			.ctrl      (control_q[i]),
			.period    (period_q[i]),
			.elapsed   (elapsed_s1),
			.prev_ovf  (ovf_chain[i]),
			.ticks_in  (ticks_q[i]),
			.latch_in  (latch_q[i]),
			.ticks_out (ticks_nx[i]),
			.latch_out (latch_nx[i]),
			.flags     (flags[i])
		);
		if (i + 1 < TIMER_SLOTS) begin : g_link
			assign ovf_chain[i+1] = flags[i].ovf;
		end
	end

	// next slice: min of deadline and prescale counts, a negative count taken as zero
	logic [CYCLE_W-1:0] slice_c;
	logic [3:0]         irq_c;
	logic [3:0]         ovf_c;

	always_comb begin
		logic [CYCLE_W-1:0] c;
		slice_c = deadline_s1;
		for (int t = 0; t < TIMER_SLOTS; t++) begin
			c = ticks_nx[t][TICKS_W-1] ? '0 : ticks_nx[t][CYCLE_W-1:0];
			if (t < TIMER_COUNT && control_q[t][1:0] == MODE_PRESCALE && c < slice_c) begin
				slice_c = c;
			end
		end
		for (int t = 0; t < TIMER_SLOTS; t++) begin
			irq_c[t] = flags[t].irq;
			ovf_c[t] = flags[t].ovf;
		end
	end

	// ---- register write decode ----
	logic                    cfg_we;
	logic                    cfg_is_ctrl;
	logic [1:0]              cfg_tmr;
	logic [PERIOD_W-1:0]     new_period;
	logic [CTRL_W-1:0]       new_ctrl;
	ticks_t                  cfg_ticks;

	assign cfg_we      = cfg.valid && cfg.ready;
	assign cfg_is_ctrl = (cfg.index >= REG_CONTROL0);
	assign cfg_tmr     = cfg.index[1:0];
	assign new_period  = cfg_is_ctrl ? period_q[cfg_tmr] : cfg.data;
	assign new_ctrl    = cfg_is_ctrl ? cfg.data[CTRL_W-1:0] : control_q[cfg_tmr];
	assign cfg_ticks   = sat28($signed({3'b000, reload_amt(new_period, new_ctrl)}));

	// ---- state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TIMER_SLOTS; t++) begin
				period_q[t]  <= FULL_PERIOD;
				control_q[t] <= '0;
				ticks_q[t]   <= ticks_t'({11'd0, FULL_PERIOD});
				latch_q[t]   <= '0;
			end
		end else begin
			if (advance) begin
				for (int t = 0; t < TIMER_SLOTS; t++) begin
					ticks_q[t] <= ticks_nx[t];
					latch_q[t] <= latch_nx[t];
				end
			end
			if (cfg_we) begin
				period_q[cfg_tmr]  <= new_period;
				control_q[cfg_tmr] <= new_ctrl;
				ticks_q[cfg_tmr]   <= cfg_ticks;
				latch_q[cfg_tmr]   <= visible_of(cfg_ticks, new_ctrl);
			end
		end
	end

	// ---- input register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			elapsed_s1  <= sample.elapsed_cycles;
			deadline_s1 <= sample.other_deadline;
		end
	end

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.irq_mask      <= irq_c;
			result_q.overflow_mask <= ovf_c;
			result_q.timer0_value  <= latch_nx[0];
			result_q.timer1_value  <= latch_nx[1];
			result_q.timer2_value  <= latch_nx[2];
			result_q.timer3_value  <= latch_nx[3];
			result_q.next_slice    <= slice_c;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.irq_mask      = result_q.irq_mask;
	assign result.overflow_mask = result_q.overflow_mask;
	assign result.timer0_value  = result_q.timer0_value;
	assign result.timer1_value  = result_q.timer1_value;
	assign result.timer2_value  = result_q.timer2_value;
	assign result.timer3_value  = result_q.timer3_value;
	assign result.next_slice    = result_q.next_slice;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-timer cascade unit.
// ----------------------------------------------------------------------------
// A short table of hand-picked words runs first: register writes and time
// slices that hit the field extremes, zero and full-scale periods, late
// overflow, count saturation, cascade chains, the reserved mode, off timers
// and prescaled visible values. A few rows carry a typed-in result; the rest
// are checked against a cycle-free timer model kept in this bench. Then eight
// blocks of random words, each behind a fresh set of register values, run
// under changing sender gaps and receiver stalls, a long receiver hold-off
// and a full drain part way through.
// ----------------------------------------------------------------------------
module tb;
	import ftcu_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 8;
	localparam int BLOCKS       = 8;
	localparam int BLOCK_WORDS  = 144;
	localparam int HOLD_CYCLES  = 64;
	localparam int TAIL_CYCLES  = 16;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [CYCLE_W-1:0]  CYCLE_MAX  = '1;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
	localparam longint TICKS_HI = (64'sd1 <<< (TICKS_W - 1)) - 1;
	localparam longint TICKS_LO = -(64'sd1 <<< (TICKS_W - 1));

	// control bits 3:2, prescale selector
	localparam logic [1:0] PRE_1    = 2'd0;
	localparam logic [1:0] PRE_64   = 2'd1;
	localparam logic [1:0] PRE_256  = 2'd2;
	localparam logic [1:0] PRE_1024 = 2'd3;
	// the fourth mode code, which the block treats as off
	localparam logic [1:0] MODE_RESERVED = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_phase_e;

	// one row of the directed table
	typedef struct {
		bit                   is_cfg;
		logic [REG_IDX_W-1:0] idx;
		logic [PERIOD_W-1:0]  data;
		logic [CYCLE_W-1:0]   elapsed;
		logic [CYCLE_W-1:0]   deadline;
		bit                   typed;
		ftcu_result_t         want;
	} drow_t;

	logic clk = 1'b0;
	logic arst_n;

	ftcu_cfg_if    cfg_bus ();
	ftcu_sample_if smp_bus ();
	ftcu_result_if res_bus ();

	four_timer_cascade_unit_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.sample (smp_bus),
		.result (res_bus)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------
	// Timer model: registers, signed counts and visible latches
	// ------------------------------------------------------------------
	logic [PERIOD_W-1:0] shadow_period [TIMER_SLOTS];
	logic [CTRL_W-1:0]   shadow_ctrl   [TIMER_SLOTS];
	ticks_t              ticks_left    [TIMER_SLOTS];
	logic [VALUE_W-1:0]  shown_value   [TIMER_SLOTS];

	ftcu_result_t pending_results [$];
	int           fault_count = 0;
	int           cycle_count = 0;

	idle_phase_e idle_phase = IDLE_NONE;
	int          hold_asks  = 0;
	int          hold_seen  = 0;
	int          hold_left  = 0;

	// cascade mode ignores the prescale selector
	function automatic int prescale_bits(logic [CTRL_W-1:0] c);
		int s;
		if (c[1:0] == MODE_CASCADE) begin
			s = 0;
		end else begin
			case (c[3:2])
				PRE_1:   s = 0;
				PRE_64:  s = 6;
				PRE_256: s = 8;
				default: s = 10;
			endcase
		end
		return s;
	endfunction

	function automatic ticks_t clamp_ticks(longint v);
		longint c;
		c = v;
		if (c > TICKS_HI) begin
			c = TICKS_HI;
		end else if (c < TICKS_LO) begin
			c = TICKS_LO;
		end
		return ticks_t'(c);
	endfunction

	// minus the floor-shifted count, low 16 bits
	function automatic logic [VALUE_W-1:0] counter_view(int t);
		longint q;
		q = longint'(ticks_left[t]) >>> prescale_bits(shadow_ctrl[t]);
		return VALUE_W'(-q);
	endfunction

	function automatic longint reload_ticks(int t);
		return longint'(shadow_period[t]) << prescale_bits(shadow_ctrl[t]);
	endfunction

	function automatic void restart_timer(int t);
		ticks_left[t]  = clamp_ticks(reload_ticks(t));
		shown_value[t] = counter_view(t);
	endfunction

	function automatic void apply_register(logic [REG_IDX_W-1:0] idx,
			logic [PERIOD_W-1:0] data);
		int t;
		if (idx < REG_CONTROL0) begin
			t = idx - REG_PERIOD0;
			shadow_period[t] = data;
		end else begin
			t = idx - REG_CONTROL0;
			shadow_ctrl[t] = data[CTRL_W-1:0];
		end
		restart_timer(t);
	endfunction

	// one time slice through the chain, 0 to 3, then the slice minimum
	function automatic ftcu_result_t advance_timers(logic [CYCLE_W-1:0] elapsed,
			logic [CYCLE_W-1:0] deadline);
		ftcu_result_t r;
		logic [3:0]   irq;
		logic [3:0]   ovf;
		logic [1:0]   m;
		longint       slice;
		longint       c;
		irq   = '0;
		ovf   = '0;
		slice = longint'(deadline);
		for (int t = 0; t < TIMER_SLOTS; t++) begin
			m = shadow_ctrl[t][1:0];
			if (m == MODE_PRESCALE || m == MODE_CASCADE) begin
				if (m == MODE_PRESCALE) begin
					ticks_left[t]  = clamp_ticks(longint'(ticks_left[t]) - longint'(elapsed));
					shown_value[t] = counter_view(t);
				end
				if (ticks_left[t] <= 0) begin
					ovf[t] = 1'b1;
					irq[t] = shadow_ctrl[t][CTRL_IRQ_BIT];
					if (t + 1 < TIMER_SLOTS && shadow_ctrl[t+1][1:0] == MODE_CASCADE) begin
						ticks_left[t+1]  = clamp_ticks(longint'(ticks_left[t+1]) - 1);
						shown_value[t+1] = counter_view(t + 1);
					end
					// added once, even if the count stays overdue
					ticks_left[t] = clamp_ticks(longint'(ticks_left[t]) + reload_ticks(t));
				end
			end
		end
		for (int t = 0; t < TIMER_SLOTS; t++) begin
			if (shadow_ctrl[t][1:0] == MODE_PRESCALE) begin
				c = (ticks_left[t] < 0) ? 0 : longint'(ticks_left[t]);
				if (c < slice) begin
					slice = c;
				end
			end
		end
		r.irq_mask      = irq;
		r.overflow_mask = ovf;
		r.timer0_value  = shown_value[0];
		r.timer1_value  = shown_value[1];
		r.timer2_value  = shown_value[2];
		r.timer3_value  = shown_value[3];
		r.next_slice    = CYCLE_W'(slice);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Table and register helpers
	// ------------------------------------------------------------------
	function automatic logic [PERIOD_W-1:0] ctrl_word(logic [1:0] mode, logic [1:0] pre,
			bit irq_en);
		return PERIOD_W'({irq_en, pre, mode});
	endfunction

	function automatic logic [REG_IDX_W-1:0] period_reg(int t);
		return REG_PERIOD0 + REG_IDX_W'(t);
	endfunction

	function automatic logic [REG_IDX_W-1:0] control_reg(int t);
		return REG_CONTROL0 + REG_IDX_W'(t);
	endfunction

	function automatic drow_t reg_row(logic [REG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] data);
		drow_t r;
		r        = '{default: '0};
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.data   = data;
		return r;
	endfunction

	function automatic drow_t tick_row(logic [CYCLE_W-1:0] e, logic [CYCLE_W-1:0] d);
		drow_t r;
		r          = '{default: '0};
		r.elapsed  = e;
		r.deadline = d;
		return r;
	endfunction

	function automatic drow_t known_row(logic [CYCLE_W-1:0] e, logic [CYCLE_W-1:0] d,
			ftcu_result_t want);
		drow_t r;
		r       = tick_row(e, d);
		r.typed = 1'b1;
		r.want  = want;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fault_count++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Drivers; every task is entered and left just after a falling edge
	// ------------------------------------------------------------------
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		apply_register(idx, data);
		@(negedge clk);
	endtask

	// lowers both valids and waits until every result word is back
	task automatic drain_results();
		cfg_bus.valid <= 1'b0;
		smp_bus.valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
	endtask

	task automatic send_slice(logic [CYCLE_W-1:0] e, logic [CYCLE_W-1:0] d, bit typed,
			ftcu_result_t want);
		int           gap_pct;
		ftcu_result_t predicted;
		gap_pct = (idle_phase == IDLE_SEND) ? 60 : (idle_phase == IDLE_BOTH) ? 28 : 0;
		cfg_bus.valid <= 1'b0;
		while ($urandom_range(0, 99) < gap_pct) begin
			smp_bus.valid <= 1'b0;
			@(negedge clk);
		end
		smp_bus.valid          <= 1'b1;
		smp_bus.elapsed_cycles <= e;
		smp_bus.other_deadline <= d;
		do @(posedge clk); while (smp_bus.ready !== 1'b1);
		// the model moves on even when the row carries its own answer
		predicted = advance_timers(e, d);
		pending_results.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stalls by phase, plus long hold-offs on request
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		int stall_pct;
		stall_pct = (idle_phase == IDLE_RECV) ? 60 : (idle_phase == IDLE_BOTH) ? 28 : 0;
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_bus.ready <= 1'b0;
		end else begin
			res_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Result check, oldest expectation first
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		ftcu_result_t want;
		if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				fault_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("irq_mask", want.irq_mask, res_bus.irq_mask);
				check_field("overflow_mask", want.overflow_mask, res_bus.overflow_mask);
				check_field("timer0_value", want.timer0_value, res_bus.timer0_value);
				check_field("timer1_value", want.timer1_value, res_bus.timer1_value);
				check_field("timer2_value", want.timer2_value, res_bus.timer2_value);
				check_field("timer3_value", want.timer3_value, res_bus.timer3_value);
				check_field("next_slice", want.next_slice, res_bus.next_slice);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		drow_t              directed [$];
		drow_t              row;
		ftcu_result_t       quiet;
		ftcu_result_t       full_slice;
		ftcu_result_t       zero_period;
		bit                 after_slice;
		logic [CYCLE_W-1:0]  el;
		logic [CYCLE_W-1:0]  dl;
		logic [PERIOD_W-1:0] per;
		logic [PERIOD_W-1:0] ctl;
		logic [1:0]          mode;
		int                  pick;

		arst_n                 = 1'b0;
		cfg_bus.valid          = 1'b0;
		cfg_bus.index          = '0;
		cfg_bus.data           = '0;
		smp_bus.valid          = 1'b0;
		smp_bus.elapsed_cycles = '0;
		smp_bus.other_deadline = '0;
		res_bus.ready          = 1'b0;

		// reset state: full period, all off, latches clear
		for (int t = 0; t < TIMER_SLOTS; t++) begin
			shadow_period[t] = FULL_PERIOD;
			shadow_ctrl[t]   = '0;
			ticks_left[t]    = ticks_t'(FULL_PERIOD);
			shown_value[t]   = '0;
		end

		// results that can be read off directly
		quiet                     = '0;
		full_slice                = '0;
		full_slice.next_slice     = CYCLE_MAX;
		zero_period               = '0;
		zero_period.irq_mask      = 4'b0001;
		zero_period.overflow_mask = 4'b0001;

		// out of reset every timer is off: nothing moves, slice is the deadline
		directed.push_back(known_row('0, '0, quiet));
		directed.push_back(known_row(CYCLE_MAX, CYCLE_MAX, full_slice));
		// period zero overflows on every slice, even with nothing elapsed
		directed.push_back(reg_row(control_reg(0), ctrl_word(MODE_PRESCALE, PRE_1, 1'b1)));
		directed.push_back(reg_row(period_reg(0), '0));
		directed.push_back(known_row('0, 27'd5, zero_period));
		// late overflow, then a count pushed past the negative limit, then overdue
		directed.push_back(reg_row(period_reg(0), PERIOD_W'(1)));
		directed.push_back(tick_row(CYCLE_MAX, 27'd1000));
		directed.push_back(tick_row(CYCLE_MAX, 27'd1000));
		directed.push_back(tick_row('0, '0));
		// cascade chain; the cascade timer's prescale bits must be ignored
		directed.push_back(reg_row(period_reg(1), PERIOD_W'(2)));
		directed.push_back(reg_row(control_reg(1), ctrl_word(MODE_CASCADE, PRE_1024, 1'b1)));
		directed.push_back(reg_row(period_reg(0), PERIOD_W'(3)));
		directed.push_back(tick_row(27'd1, CYCLE_MAX));
		directed.push_back(tick_row(27'd2, CYCLE_MAX));
		directed.push_back(tick_row(27'd5, CYCLE_MAX));
		// three-deep chain, last timer in the reserved mode
		directed.push_back(reg_row(period_reg(2), PERIOD_W'(1)));
		directed.push_back(reg_row(control_reg(2), ctrl_word(MODE_CASCADE, PRE_1, 1'b0)));
		directed.push_back(reg_row(control_reg(3), ctrl_word(MODE_RESERVED, PRE_256, 1'b1)));
		directed.push_back(tick_row(27'd3, 27'd77));
		directed.push_back(tick_row(27'd3, 27'd77));
		directed.push_back(tick_row(27'd3, 27'd77));
		// largest period at the largest prescale
		directed.push_back(reg_row(period_reg(3), PERIOD_MAX));
		directed.push_back(reg_row(control_reg(3), ctrl_word(MODE_PRESCALE, PRE_1024, 1'b1)));
		directed.push_back(tick_row(27'h7FFFBFF, CYCLE_MAX));
		directed.push_back(tick_row(27'd1, CYCLE_MAX));
		// prescaled visible value on timer 0
		directed.push_back(reg_row(control_reg(0), ctrl_word(MODE_PRESCALE, PRE_64, 1'b0)));
		directed.push_back(reg_row(period_reg(0), PERIOD_MAX));
		directed.push_back(tick_row(27'd100, 27'd12345));
		directed.push_back(tick_row(27'h12345, '0));
		// an off timer keeps its count and its latch
		directed.push_back(reg_row(control_reg(2), ctrl_word(MODE_OFF, PRE_1, 1'b0)));
		directed.push_back(tick_row(27'd7, 27'd300));
		// junk above the control field is dropped
		directed.push_back(reg_row(control_reg(1),
			ctrl_word(MODE_PRESCALE, PRE_256, 1'b1) | 17'h1FFE0));
		directed.push_back(tick_row(27'd1, 27'd1));
		directed.push_back(tick_row(27'h5555555, 27'h2AAAAAA));
		directed.push_back(tick_row(27'h2AAAAAA, 27'h5555555));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed table ---
		after_slice = 1'b0;
		foreach (directed[i]) begin
			row = directed[i];
			if (row.is_cfg) begin
				// registers only change with nothing in flight
				if (after_slice) begin
					drain_results();
				end
				write_reg(row.idx, row.data);
				after_slice = 1'b0;
			end else begin
				send_slice(row.elapsed, row.deadline, row.typed, row.want);
				after_slice = 1'b1;
			end
		end

		// --- random blocks, each with its own register set ---
		for (int blk = 0; blk < BLOCKS; blk++) begin
			drain_results();
			for (int t = 0; t < TIMER_SLOTS; t++) begin
				if (blk == 0) begin
					// period of one, whole chain cascading off timer 0
					per = PERIOD_W'(1);
					ctl = (t == 0) ? ctrl_word(MODE_PRESCALE, PRE_1, 1'b1)
						: ctrl_word(MODE_CASCADE, PRE_1, 1'b1);
				end else if (blk == 1) begin
					// longest reload there is
					per = PERIOD_MAX;
					ctl = ctrl_word(MODE_PRESCALE, PRE_1024, 1'b1);
				end else begin
					pick = $urandom_range(0, 9);
					case (pick)
						0:       per = '0;
						1:       per = PERIOD_W'(1);
						2:       per = PERIOD_W'($urandom_range(2, 16));
						3, 4:    per = PERIOD_W'($urandom_range(17, 1000));
						5:       per = FULL_PERIOD;
						6:       per = PERIOD_MAX;
						7:       per = PERIOD_W'($urandom_range(1, 100));
						default: per = PERIOD_W'($urandom);
					endcase
					pick = $urandom_range(0, 9);
					mode = (pick < 4) ? MODE_PRESCALE : (pick < 8) ? MODE_CASCADE
						: (pick == 8) ? MODE_OFF : MODE_RESERVED;
					ctl = ctrl_word(mode, 2'($urandom_range(0, 3)), 1'($urandom));
					if ($urandom_range(0, 3) == 0) begin
						ctl = ctl | (PERIOD_W'($urandom) & 17'h1FFE0);
					end
				end
				write_reg(period_reg(t), per);
				write_reg(control_reg(t), ctl);
			end

			for (int n = 0; n < BLOCK_WORDS; n++) begin
				idle_phase <= idle_phase_e'(((n / 36) + blk) % 4);
				// long receiver hold-off while words keep coming
				if (n == 20) begin
					hold_asks <= hold_asks + 1;
				end
				// sender waits for the pipe to empty
				if (n == 90) begin
					drain_results();
				end
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					el = CYCLE_W'($urandom_range(0, 6));
				end else if (pick < 75) begin
					el = CYCLE_W'($urandom_range(0, 400));
				end else if (pick < 90) begin
					el = CYCLE_W'($urandom_range(0, 140000));
				end else if (pick < 97) begin
					el = CYCLE_W'($urandom);
				end else begin
					el = CYCLE_MAX;
				end
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					dl = CYCLE_W'($urandom_range(0, 50));
				end else if (pick < 50) begin
					dl = CYCLE_W'($urandom);
				end else if (pick < 95) begin
					dl = CYCLE_W'($urandom_range(0, 200000));
				end else begin
					dl = CYCLE_MAX;
				end
				send_slice(el, dl, 1'b0, quiet);
			end
		end

		// --- wind down: catch stragglers, then the verdict ---
		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fault_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
